[rtl/core/tcw_pkg.sv]
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, codes and constants of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    // Default screen geometry
    localparam int SCREEN_COLUMNS_DEF = 80;
    localparam int SCREEN_ROWS_DEF    = 25;

    // Field widths
    localparam int CHAR_W      = 8;
    localparam int COLOR_W     = 4;
    localparam int CELL_W      = 16;
    localparam int KIND_W      = 2;
    localparam int POS_W       = 11;
    localparam int IN_ADDR_W   = 11;
    localparam int S_TDATA_W   = 24;
    localparam int M_TDATA_W   = 32;
    localparam int CFG_INDEX_W = 1;

    // Item kinds
    localparam logic [KIND_W-1:0] KIND_PUT       = 2'd0;
    localparam logic [KIND_W-1:0] KIND_BACKSPACE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ      = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_FOREGROUND = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_BACKGROUND = 1'd1;

    // Characters and colors
    localparam logic [CHAR_W-1:0]  CHAR_NEWLINE = 8'd10;
    localparam logic [CHAR_W-1:0]  CHAR_SPACE   = 8'd32;
    localparam logic [COLOR_W-1:0] RESET_FG     = 4'd7;
    localparam logic [COLOR_W-1:0] RESET_BG     = 4'd0;
    localparam logic [CELL_W-1:0]  RESET_CELL   = {RESET_BG, RESET_FG, CHAR_SPACE};

    // What one item does to the screen store
    typedef struct packed {
        logic wr_en;   // item writes one cell
        logic blank;   // written cell is a blank, not the item's character
        logic scroll;  // item steps past the last row
    } cur_act_t;

    // Cell: character low byte, foreground, background on top
    function automatic logic [CELL_W-1:0] make_cell(
        input logic [CHAR_W-1:0]  ch,
        input logic [COLOR_W-1:0] fg,
        input logic [COLOR_W-1:0] bg
    );
        return {bg, fg, ch};
    endfunction

endpackage

[rtl/core/tcw_ram.sv]
// ----------------------------------------------------------------------------
// tcw_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000,
    localparam int AW   = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/core/tcw_cursor.sv]
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor row, column and linear position; decodes what an item writes.
// ----------------------------------------------------------------------------
module tcw_cursor #(
    parameter int SCREEN_COLUMNS = 80,
    parameter int SCREEN_ROWS    = 25,
    localparam int AW            = $clog2(SCREEN_COLUMNS * SCREEN_ROWS)
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  item_fire,
    input  logic [1:0]            kind,
    input  logic [7:0]            char_code,
    output tcw_pkg::cur_act_t     act,
    output logic [AW-1:0]         wr_addr,
    output logic [AW-1:0]         cursor_lin
);
    import tcw_pkg::*;

    localparam int COL_W = $clog2(SCREEN_COLUMNS);
    localparam int ROW_W = $clog2(SCREEN_ROWS);
    localparam int LAST_ROW_START = (SCREEN_ROWS - 1) * SCREEN_COLUMNS;

    logic [COL_W-1:0] col_reg, col_next;
    logic [ROW_W-1:0] row_reg, row_next;
    logic [AW-1:0]    lin_reg, lin_next;
    logic [COL_W:0]   col_inc;
    logic             is_newline;
    logic             wrap;

    assign col_inc    = {1'b0, col_reg} + 1'b1;
    assign is_newline = (char_code == CHAR_NEWLINE);
    assign wrap       = (col_inc >= (COL_W+1)'(SCREEN_COLUMNS)) || is_newline;

    // Next cursor and cell write for the offered item
    always_comb begin
        col_next = col_reg;
        row_next = row_reg;
        lin_next = lin_reg;
        act      = '0;
        wr_addr  = lin_reg;
        case (kind)
            KIND_PUT: begin
                act.wr_en = !is_newline;
                if (!wrap) begin
                    col_next = col_inc[COL_W-1:0];
                    lin_next = lin_reg + 1'b1;
                end else begin
                    col_next = '0;
                    if (row_reg == ROW_W'(SCREEN_ROWS - 1)) begin
                        act.scroll = 1'b1;
                        lin_next   = AW'(LAST_ROW_START);
                    end else begin
                        row_next = row_reg + 1'b1;
                        // newline jumps to the next row start
                        lin_next = lin_reg + (AW'(SCREEN_COLUMNS) - AW'(col_reg));
                    end
                end
            end
            KIND_BACKSPACE: begin
                if (col_reg != '0) begin
                    act.wr_en = 1'b1;
                    act.blank = 1'b1;
                    col_next  = col_reg - 1'b1;
                    lin_next  = lin_reg - 1'b1;
                    wr_addr   = lin_reg - 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg <= '0;
            row_reg <= '0;
            lin_reg <= '0;
        end else if (item_fire) begin
            col_reg <= col_next;
            row_reg <= row_next;
            lin_reg <= lin_next;
        end
    end

    assign cursor_lin = lin_reg;

endmodule

[rtl/core/text_console_writer_top.sv]
// ----------------------------------------------------------------------------
// text_console_writer_top
// Text-mode console writer: screen store in RAM plus cursor tracking.
// ----------------------------------------------------------------------------
// Every item is taken in ST_IDLE, the only state with s_tready high; its result
// is built in ST_RESP and registered, and a stalled result output holds ST_RESP.
// A scrolling put first goes through ST_COPY, where the RAM copies one cell a
// cycle one row up, then ST_BLANK, which blanks the bottom row one cell a cycle.
// Reset: cursor to 0, colors to light grey on black; a clearing pass fills the
// RAM with blanks, no items taken meanwhile.
module text_console_writer_top #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // input: tdata = char_code[7:0], cell_address[18:8], zero fill
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0]     s_tdata,
    // input: tuser = kind[1:0]
    input  logic [tcw_pkg::KIND_W-1:0]        s_tuser,
    // result: tdata = cursor_position[10:0], cell_data[26:11], scrolled[27], zero fill
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [tcw_pkg::M_TDATA_W-1:0]     m_tdata,
    // configuration writes
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]       cfg_data
);
    import tcw_pkg::*;

    localparam int CELL_COUNT     = SCREEN_COLUMNS * SCREEN_ROWS;
    localparam int AW             = $clog2(CELL_COUNT);
    localparam int PTR_W          = AW + 1;
    localparam int CMP_W          = (PTR_W > IN_ADDR_W) ? PTR_W : IN_ADDR_W;
    localparam int EXT_W          = (AW > POS_W) ? AW : POS_W;
    localparam int LAST_ROW_START = CELL_COUNT - SCREEN_COLUMNS;

    typedef enum logic [4:0] {
        ST_CLEAR = 5'b00001,
        ST_IDLE  = 5'b00010,
        ST_RESP  = 5'b00100,
        ST_COPY  = 5'b01000,
        ST_BLANK = 5'b10000
    } state_t;

    state_t               state_reg, state_next;
    logic [AW-1:0]        wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]     rd_ptr_reg, rd_ptr_next;
    logic                 pend_reg, pend_next;
    logic                 read_hit_reg, read_hit_next;
    logic                 scroll_reg, scroll_next;
    logic [COLOR_W-1:0]   fg_reg, bg_reg;
    logic                 m_valid_reg, m_valid_next;
    logic [M_TDATA_W-1:0] m_data_reg, m_data_next;

    // Input field unpacking
    logic [KIND_W-1:0]    in_kind;
    logic [CHAR_W-1:0]    in_char;
    logic [IN_ADDR_W-1:0] in_addr;
    logic [CMP_W-1:0]     in_addr_ext;
    logic                 item_fire;
    logic                 read_ok;

    assign in_kind     = s_tuser;
    assign in_char     = s_tdata[CHAR_W-1:0];
    assign in_addr     = s_tdata[CHAR_W +: IN_ADDR_W];
    assign in_addr_ext = CMP_W'(in_addr);
    assign s_tready    = (state_reg == ST_IDLE);
    assign item_fire   = s_tvalid && s_tready;
    assign read_ok     = (in_kind == KIND_READ) && (in_addr_ext < CMP_W'(CELL_COUNT));

    // Cursor tracking
    cur_act_t       act;
    logic [AW-1:0]  cur_wr_addr;
    logic [AW-1:0]  cursor_lin;
    logic [EXT_W-1:0] cursor_ext;

    tcw_cursor #(
        .SCREEN_COLUMNS (SCREEN_COLUMNS),
        .SCREEN_ROWS    (SCREEN_ROWS)
    ) u_cursor (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_fire  (item_fire),
        .kind       (in_kind),
        .char_code  (in_char),
        .act        (act),
        .wr_addr    (cur_wr_addr),
        .cursor_lin (cursor_lin)
    );

    assign cursor_ext = EXT_W'(cursor_lin);

    // Screen store
    logic              ram_wr_en;
    logic [AW-1:0]     ram_wr_addr;
    logic [CELL_W-1:0] ram_wr_data;
    logic              ram_rd_en;
    logic [AW-1:0]     ram_rd_addr;
    logic [CELL_W-1:0] ram_rd_data;

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELL_COUNT)
    ) u_screen (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Configuration registers
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fg_reg <= RESET_FG;
            bg_reg <= RESET_BG;
        end else if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_FOREGROUND: fg_reg <= cfg_data;
                REG_BACKGROUND: bg_reg <= cfg_data;
                default: begin
                end
            endcase
        end
    end

    // Sequencer: item handling, scroll copy, bottom-row blank, reset clear
    always_comb begin
        state_next    = state_reg;
        wr_ptr_next   = wr_ptr_reg;
        rd_ptr_next   = rd_ptr_reg;
        pend_next     = pend_reg;
        read_hit_next = read_hit_reg;
        scroll_next   = scroll_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        ram_wr_en     = 1'b0;
        ram_wr_addr   = wr_ptr_reg;
        ram_wr_data   = make_cell(CHAR_SPACE, fg_reg, bg_reg);
        ram_rd_en     = 1'b0;
        ram_rd_addr   = rd_ptr_reg[AW-1:0];

        unique case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_data = RESET_CELL;
                wr_ptr_next = wr_ptr_reg + 1'b1;
                if (wr_ptr_reg == AW'(CELL_COUNT - 1)) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (item_fire) begin
                    ram_wr_en     = act.wr_en;
                    ram_wr_addr   = cur_wr_addr;
                    ram_wr_data   = make_cell(act.blank ? CHAR_SPACE : in_char,
                                              fg_reg, bg_reg);
                    ram_rd_en     = read_ok;
                    ram_rd_addr   = in_addr_ext[AW-1:0];
                    read_hit_next = read_ok;
                    scroll_next   = act.scroll;
                    if (act.scroll) begin
                        wr_ptr_next = '0;
                        rd_ptr_next = PTR_W'(SCREEN_COLUMNS);
                        pend_next   = 1'b0;
                        state_next  = ST_COPY;
                    end else begin
                        state_next = ST_RESP;
                    end
                end
            end
            ST_COPY: begin
                // read one row ahead, write the cell fetched last cycle
                ram_wr_en   = pend_reg;
                ram_wr_data = ram_rd_data;
                if (pend_reg) begin
                    wr_ptr_next = wr_ptr_reg + 1'b1;
                end
                if (rd_ptr_reg != PTR_W'(CELL_COUNT)) begin
                    ram_rd_en   = 1'b1;
                    rd_ptr_next = rd_ptr_reg + 1'b1;
                    pend_next   = 1'b1;
                end else begin
                    pend_next  = 1'b0;
                    state_next = ST_BLANK;
                end
            end
            ST_BLANK: begin
                ram_wr_en   = 1'b1;
                wr_ptr_next = wr_ptr_reg + 1'b1;
                if (wr_ptr_reg == AW'(CELL_COUNT - 1)) begin
                    state_next = ST_RESP;
                end
            end
            ST_RESP: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = M_TDATA_W'({scroll_reg,
                                               read_hit_reg ? ram_rd_data : CELL_W'(0),
                                               cursor_ext[POS_W-1:0]});
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_CLEAR;
            wr_ptr_reg   <= '0;
            rd_ptr_reg   <= '0;
            pend_reg     <= 1'b0;
            read_hit_reg <= 1'b0;
            scroll_reg   <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wr_ptr_reg   <= wr_ptr_next;
            rd_ptr_reg   <= rd_ptr_next;
            pend_reg     <= pend_next;
            read_hit_reg <= read_hit_next;
            scroll_reg   <= scroll_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    // Checks
    a_scroll_starts_copy: assert property (@(posedge aclk) disable iff (!aresetn)
        (item_fire && act.scroll) |=> (state_reg == ST_COPY))
        else $error("scrolling put did not start the copy sweep");

    a_blank_in_bottom_row: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_BLANK) |-> (wr_ptr_reg >= AW'(LAST_ROW_START)))
        else $error("blank sweep outside the bottom row");

    a_resp_waits_for_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_RESP && m_valid_reg && !m_tready) |=> (state_reg == ST_RESP))
        else $error("result overwrote a pending output transaction");

    a_copy_write_pending: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_COPY && rd_ptr_reg == PTR_W'(CELL_COUNT)) |-> pend_reg)
        else $error("copy sweep lost its last fetched cell");

endmodule

[sim/tcw_report_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_report_checker
// Watches the input, result and color-write channels of the text console
// writer, keeps a shadow screen and cursor, and compares every result
// transaction field by field with the oldest predicted report.
// ----------------------------------------------------------------------------
module tcw_report_checker #(
    parameter int SCREEN_COLUMNS = tcw_pkg::SCREEN_COLUMNS_DEF,
    parameter int SCREEN_ROWS    = tcw_pkg::SCREEN_ROWS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [tcw_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [tcw_pkg::KIND_W-1:0]      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [tcw_pkg::M_TDATA_W-1:0]   m_tdata,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [tcw_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [tcw_pkg::COLOR_W-1:0]     cfg_data,
    output int                              error_count,
    output int                              pending_count
);
    import tcw_pkg::*;

    localparam int CELL_COUNT = SCREEN_COLUMNS * SCREEN_ROWS;

    typedef struct packed {
        logic [POS_W-1:0]  position;
        logic [CELL_W-1:0] cell_data;
        logic              scrolled;
    } console_report_t;

    // Shadow of the screen store, cursor and colors
    logic [CELL_W-1:0]  shadow_cells [0:CELL_COUNT-1];
    int                 shadow_row;
    int                 shadow_col;
    logic [COLOR_W-1:0] shadow_fg;
    logic [COLOR_W-1:0] shadow_bg;

    console_report_t    pending_reports [$];

    function automatic logic [CELL_W-1:0] colored_cell(input logic [CHAR_W-1:0] ch);
        return {shadow_bg, shadow_fg, ch};
    endfunction

    // Applies one item to the shadow state and returns the report it causes
    function automatic console_report_t apply_console_item(
        input logic [KIND_W-1:0]    kind,
        input logic [CHAR_W-1:0]    ch,
        input logic [IN_ADDR_W-1:0] addr
    );
        console_report_t rep;
        rep = '0;
        case (kind)
            KIND_PUT: begin
                if (ch != CHAR_NEWLINE)
                    shadow_cells[shadow_row * SCREEN_COLUMNS + shadow_col] = colored_cell(ch);
                shadow_col++;
                if (shadow_col >= SCREEN_COLUMNS || ch == CHAR_NEWLINE) begin
                    shadow_col = 0;
                    shadow_row++;
                    if (shadow_row >= SCREEN_ROWS) begin
                        // screen moves up one line, bottom line blanked
                        for (int i = 0; i < CELL_COUNT - SCREEN_COLUMNS; i++)
                            shadow_cells[i] = shadow_cells[i + SCREEN_COLUMNS];
                        for (int i = CELL_COUNT - SCREEN_COLUMNS; i < CELL_COUNT; i++)
                            shadow_cells[i] = colored_cell(CHAR_SPACE);
                        shadow_row   = SCREEN_ROWS - 1;
                        rep.scrolled = 1'b1;
                    end
                end
            end
            KIND_BACKSPACE: begin
                // no effect at column zero
                if (shadow_col > 0) begin
                    shadow_col--;
                    shadow_cells[shadow_row * SCREEN_COLUMNS + shadow_col] =
                        colored_cell(CHAR_SPACE);
                end
            end
            KIND_READ: begin
                // reads past the screen return zero
                if (addr < CELL_COUNT)
                    rep.cell_data = shadow_cells[addr];
            end
            default: ;
        endcase
        rep.position = POS_W'(shadow_row * SCREEN_COLUMNS + shadow_col);
        return rep;
    endfunction

    always @(posedge aclk) begin
        console_report_t want;
        console_report_t got;
        if (!aresetn) begin
            shadow_row  = 0;
            shadow_col  = 0;
            shadow_fg   = RESET_FG;
            shadow_bg   = RESET_BG;
            for (int i = 0; i < CELL_COUNT; i++)
                shadow_cells[i] = {RESET_BG, RESET_FG, CHAR_SPACE};
            pending_reports.delete();
            error_count   = 0;
            pending_count = 0;
        end else begin
            // color register writes
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_FOREGROUND: shadow_fg = cfg_data;
                    REG_BACKGROUND: shadow_bg = cfg_data;
                    default: ;
                endcase
            end

            // result transaction against the oldest report
            if (m_tvalid && m_tready) begin
                got.position  = m_tdata[10:0];
                got.cell_data = m_tdata[26:11];
                got.scrolled  = m_tdata[27];
                if (pending_reports.size() == 0) begin
                    $error("unexpected result transaction: tdata %h", m_tdata);
                    error_count++;
                end else begin
                    want = pending_reports.pop_front();
                    if (got.position !== want.position) begin
                        $error("cursor_position mismatch: expected %0d, actual %0d",
                               want.position, got.position);
                        error_count++;
                    end
                    if (got.cell_data !== want.cell_data) begin
                        $error("cell_data mismatch: expected %h, actual %h",
                               want.cell_data, got.cell_data);
                        error_count++;
                    end
                    if (got.scrolled !== want.scrolled) begin
                        $error("scrolled mismatch: expected %b, actual %b",
                               want.scrolled, got.scrolled);
                        error_count++;
                    end
                end
            end

            // input transaction: predict its report
            if (s_tvalid && s_tready)
                pending_reports.push_back(apply_console_item(s_tuser, s_tdata[7:0],
                                                             s_tdata[18:8]));

            pending_count = pending_reports.size();
        end
    end

endmodule

[sim/tb_text_console_writer_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_writer_top
// Drives the text console writer with a short directed sequence and then
// bursts of random puts, newlines, backspaces and reads under several color
// settings, with random gaps and result-side stalls. A separate checker
// predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_text_console_writer_top;
    import tcw_pkg::*;

    localparam logic [KIND_W-1:0] KIND_UNUSED  = 2'd3;
    localparam int                CYCLE_LIMIT  = 10_000_000;
    localparam int                PHASE_ITEMS  = 195;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [S_TDATA_W-1:0]   s_tdata;    // char_code[7:0], cell_address[18:8], zero fill
    logic [KIND_W-1:0]      s_tuser;    // kind[1:0]
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;    // cursor_position[10:0], cell_data[26:11], scrolled[27]
    logic                   cfg_valid;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [COLOR_W-1:0]     cfg_data;
    int                     error_count;
    int                     pending_count;
    int                     cycle_count;

    text_console_writer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    tcw_report_checker checker_i (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata),
        .s_tuser       (s_tuser),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .m_tdata       (m_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .error_count   (error_count),
        .pending_count (pending_count)
    );

    // 12 ns clock
    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        cycle_count = 0;
        while (cycle_count <= CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("RESULT: ERROR");
        $finish;
    end

    // Result-side stalls: stretches of always ready, random, mostly stalled, toggling
    initial begin
        int mode;
        int span;
        m_tready = 1'b0;
        forever begin
            mode = $urandom_range(0, 3);
            span = $urandom_range(4, 40);
            repeat (span) begin
                @(negedge aclk);
                case (mode)
                    0:       m_tready = 1'b1;
                    1:       m_tready = 1'($urandom_range(0, 1));
                    2:       m_tready = ($urandom_range(0, 7) == 0);
                    default: m_tready = ~m_tready;
                endcase
            end
        end
    end

    // One input transaction; returns at the accepting edge, valid left high
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [CHAR_W-1:0] ch,
                             input logic [IN_ADDR_W-1:0] addr);
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser  = kind;
        s_tdata  = {5'b0, addr, ch};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Drop valid and wait until every report has come back
    task automatic drain_reports();
        @(negedge aclk);
        s_tvalid = 1'b0;
        while (pending_count != 0) @(negedge aclk);
    endtask

    task automatic write_color_reg(input logic [CFG_INDEX_W-1:0] idx,
                                   input logic [COLOR_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    // Mostly text with newlines and edits, some reads, a little unused-kind noise
    task automatic send_random_item();
        int                   pick;
        int                   sel;
        logic [KIND_W-1:0]    kind;
        logic [CHAR_W-1:0]    ch;
        logic [IN_ADDR_W-1:0] addr;
        pick = $urandom_range(0, 99);
        ch   = CHAR_W'($urandom_range(0, 255));
        addr = IN_ADDR_W'($urandom_range(0, 2047));
        if (pick < 58) begin
            kind = KIND_PUT;
            if ($urandom_range(0, 9) == 0)
                ch = CHAR_NEWLINE;
        end else if (pick < 72) begin
            kind = KIND_BACKSPACE;
        end else if (pick < 96) begin
            kind = KIND_READ;
            sel  = $urandom_range(0, 9);
            if (sel < 4)
                addr = IN_ADDR_W'($urandom_range(1920, 1999));   // bottom row, where the cursor settles
            else if (sel < 8)
                addr = IN_ADDR_W'($urandom_range(0, 1999));
            else
                addr = IN_ADDR_W'($urandom_range(2000, 2047));   // past the screen
        end else begin
            kind = KIND_UNUSED;
        end
        send_item(kind, ch, addr);
    endtask

    // Bursts of random length separated by random gaps
    task automatic run_random_phase(input int count);
        int sent;
        int burst;
        int gap;
        sent = 0;
        while (sent < count) begin
            burst = $urandom_range(1, 20);
            repeat (burst) begin
                if (sent < count) begin
                    send_random_item();
                    sent++;
                end
            end
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                @(negedge aclk);
                s_tvalid = 1'b0;
                repeat (gap - 1) @(negedge aclk);
            end
        end
        drain_reports();
    endtask

    // Stimulus and verdict
    initial begin
        aresetn   = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = KIND_PUT;
        cfg_valid = 1'b0;
        cfg_index = REG_FOREGROUND;
        cfg_data  = '0;
        repeat (4) @(negedge aclk);
        aresetn = 1'b1;

        // directed: reset contents, out-of-range reads, edits at column zero
        send_item(KIND_READ, 8'h00, 11'd0);
        send_item(KIND_READ, 8'hFF, 11'd1999);
        send_item(KIND_READ, 8'h00, 11'd2000);
        send_item(KIND_READ, 8'hFF, 11'd2047);
        send_item(KIND_BACKSPACE, 8'h00, 11'd0);
        send_item(KIND_UNUSED, 8'hFF, 11'd2047);
        send_item(KIND_PUT, 8'h41, 11'd0);
        send_item(KIND_PUT, 8'hFF, 11'd0);
        send_item(KIND_PUT, 8'h00, 11'd0);
        send_item(KIND_READ, 8'h00, 11'd1);
        send_item(KIND_READ, 8'h00, 11'd2);
        send_item(KIND_BACKSPACE, 8'hFF, 11'd2047);
        send_item(KIND_READ, 8'h00, 11'd2);
        send_item(KIND_PUT, CHAR_NEWLINE, 11'd0);
        send_item(KIND_BACKSPACE, 8'h00, 11'd0);
        send_item(KIND_PUT, 8'h55, 11'd0);
        send_item(KIND_PUT, 8'hAA, 11'd0);
        send_item(KIND_READ, 8'h00, 11'd80);
        send_item(KIND_READ, 8'h00, 11'd81);
        send_item(KIND_PUT, CHAR_NEWLINE, 11'd0);
        send_item(KIND_PUT, CHAR_NEWLINE, 11'd0);
        send_item(KIND_READ, 8'h00, 11'd0);
        drain_reports();

        // random phases under different colors, extremes included
        write_color_reg(REG_FOREGROUND, 4'hF);
        write_color_reg(REG_BACKGROUND, 4'hF);
        run_random_phase(PHASE_ITEMS);

        write_color_reg(REG_BACKGROUND, 4'h0);
        write_color_reg(REG_FOREGROUND, 4'h0);
        run_random_phase(PHASE_ITEMS);

        write_color_reg(REG_FOREGROUND, COLOR_W'($urandom_range(1, 14)));
        write_color_reg(REG_BACKGROUND, COLOR_W'($urandom_range(1, 14)));
        run_random_phase(PHASE_ITEMS);

        write_color_reg(REG_FOREGROUND, 4'h0);
        write_color_reg(REG_BACKGROUND, 4'hF);
        run_random_phase(PHASE_ITEMS);

        // let any stray result show up
        repeat (16) @(negedge aclk);
        if (error_count == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
